// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VNE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VNE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define VNE_ASSERT(label, clk, rst_n, prop, msg)
`define VNE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- hw/rtl/vne_pkg.sv -----
package vne_pkg;
    localparam int unsigned NumLanes   = 4;
    localparam int unsigned SqrtCells  = 33;
    localparam int unsigned DivCells   = 17;
    localparam logic [2:0]  CountReset = 3'd3;

    typedef struct packed {
        logic                  valid;
        logic [65:0]           rad;
        logic [34:0]           rem;
        logic [32:0]           root;
        logic [3:0][31:0]      mag;
        logic [3:0]            neg;
    } t_sq_stage;

    typedef struct packed {
        logic                  valid;
        logic [32:0]           root;
        logic [3:0][32:0]      rem;
        logic [3:0][16:0]      dvd;
        logic [3:0][16:0]      quo;
        logic [3:0]            neg;
    } t_dv_stage;
endpackage

// ----- hw/rtl/vector_normalize_exact_unit.sv -----
// Channel | Direction | Handshake            | Payload
// s       | in        | i_s_tvalid/o_s_tready | i_s_tdata: comp_x, comp_y, comp_z, comp_w
// m       | out       | o_m_tvalid/i_m_tready | o_m_tdata: unit_x..unit_w, vec_length
// cfg     | in        | i_cfg_we             | i_cfg_wdata: components_in_use
// One vector is accepted every cycle while the output is not stalled.
// The latency is set by 4 front stages, 33 root cells, 17 divide cells and the output register.
// Synchronous active-low reset clears all valid flags and sets the count to 3.
// A stalled output holds the whole pipeline, which then holds o_s_tready low.
module vector_normalize_exact_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // comp_x, comp_y, comp_z, comp_w
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [159:0] o_m_tdata,   // unit_x, unit_y, unit_z, unit_w, vec_length
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_wdata
);
    import vne_pkg::*;
    `include "assert_macros.svh"

    logic                       w_en;
    logic [2:0]                 r_count;
    logic [NumLanes-1:0]        w_used;

    logic                       r_v0, r_v1, r_v2, r_v3;
    logic [3:0][31:0]           r_mag0, r_mag1, r_mag2, r_mag3;
    logic [3:0]                 r_neg0, r_neg1, r_neg2, r_neg3;
    logic [3:0][63:0]           r_sq;
    logic [1:0][64:0]           r_pair;
    logic [64:0]                r_sum;
    t_sq_stage                  w_sq_in;
    t_dv_stage                  w_dv_in;
    t_sq_stage                  w_sq [SqrtCells+1];
    t_dv_stage                  w_dv [DivCells+1];
    logic                       r_out_v;
    logic [159:0]               r_out;
    logic [159:0]               n_out;
    logic [3:0][31:0]           w_raw;

    assign w_en       = !r_out_v || i_m_tready;
    assign o_s_tready = w_en;
    assign w_raw      = i_s_tdata;

    always_comb begin
        w_used[0] = 1'b1;
        w_used[1] = 1'b1;
        w_used[2] = (r_count >= 3'd3);
        w_used[3] = (r_count >= 3'd4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CountReset;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v0    <= i_s_tvalid;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_out_v <= w_dv[DivCells].valid;
        end
        if (w_en) begin
            for (int i = 0; i < NumLanes; i++) begin
                r_neg0[i] <= w_used[i] && w_raw[i][31];
                r_mag0[i] <= !w_used[i] ? 32'd0 :
                             (w_raw[i][31] ? 32'(-w_raw[i]) : w_raw[i]);
                r_sq[i]   <= 64'(r_mag0[i]) * 64'(r_mag0[i]);
            end
            r_mag1    <= r_mag0;
            r_neg1    <= r_neg0;
            r_pair[0] <= 65'(r_sq[0]) + 65'(r_sq[1]);
            r_pair[1] <= 65'(r_sq[2]) + 65'(r_sq[3]);
            r_mag2    <= r_mag1;
            r_neg2    <= r_neg1;
            r_sum     <= r_pair[0] + r_pair[1];
            r_mag3    <= r_mag2;
            r_neg3    <= r_neg2;
            r_out     <= n_out;
        end
    end

    always_comb begin
        w_sq_in.valid = r_v3;
        w_sq_in.rad   = {1'b0, r_sum};
        w_sq_in.rem   = '0;
        w_sq_in.root  = '0;
        w_sq_in.mag   = r_mag3;
        w_sq_in.neg   = r_neg3;
    end

    assign w_sq[0] = w_sq_in;

    for (genvar g = 0; g < SqrtCells; g++) begin : g_sqrt
        vne_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_sq[g]),
            .o_stage (w_sq[g+1])
        );
    end

    always_comb begin
        w_dv_in.valid = w_sq[SqrtCells].valid;
        w_dv_in.root  = w_sq[SqrtCells].root;
        w_dv_in.neg   = w_sq[SqrtCells].neg;
        w_dv_in.quo   = '0;
        for (int i = 0; i < NumLanes; i++) begin
            w_dv_in.rem[i] = {2'b00, w_sq[SqrtCells].mag[i][31:1]};
            w_dv_in.dvd[i] = {w_sq[SqrtCells].mag[i][0], 16'd0};
        end
    end

    assign w_dv[0] = w_dv_in;

    for (genvar g = 0; g < DivCells; g++) begin : g_div
        vne_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_dv[g]),
            .o_stage (w_dv[g+1])
        );
    end

    always_comb begin
        n_out = '0;
        for (int i = 0; i < NumLanes; i++) begin
            if (w_dv[DivCells].root != 33'd0) begin
                n_out[i*32 +: 32] = w_dv[DivCells].neg[i] ?
                    32'(-{15'd0, w_dv[DivCells].quo[i]}) : {15'd0, w_dv[DivCells].quo[i]};
            end
        end
        n_out[159:128] = w_dv[DivCells].root[32] ? 32'hFFFF_FFFF : w_dv[DivCells].root[31:0];
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;

    `VNE_ASSERT(a_stall_blocks_input, i_clk, i_rst_n,
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready, "input taken while output stalled")
    `VNE_ASSERT(a_zero_length_zero_units, i_clk, i_rst_n,
        (o_m_tvalid && o_m_tdata[159:128] == 32'd0) |-> (o_m_tdata[127:0] == 128'd0),
        "zero length with nonzero components")
    `VNE_ASSERT(a_unused_w_zero, i_clk, i_rst_n,
        (o_m_tvalid && r_count < 3'd4) |-> (o_m_tdata[127:96] == 32'd0),
        "unused fourth component not zero")
    `VNE_ASSERT_NEXT(a_stall_holds_result, i_clk, i_rst_n,
        (o_m_tvalid && !i_m_tready), (o_m_tvalid && $stable(r_out)),
        "stalled result changed")
endmodule

// ----- hw/rtl/vne_sqrt_cell.sv -----
module vne_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  vne_pkg::t_sq_stage i_stage,
    output vne_pkg::t_sq_stage o_stage
);
    import vne_pkg::*;

    t_sq_stage   r_stage;
    t_sq_stage   n_stage;
    logic [36:0] w_tmp;
    logic [36:0] w_trial;

    always_comb begin
        n_stage     = i_stage;
        w_tmp       = {i_stage.rem, i_stage.rad[65:64]};
        w_trial     = {2'b00, i_stage.root, 2'b01};
        n_stage.rad = {i_stage.rad[63:0], 2'b00};
        if (w_tmp >= w_trial) begin
            n_stage.rem  = 35'(w_tmp - w_trial);
            n_stage.root = {i_stage.root[31:0], 1'b1};
        end else begin
            n_stage.rem  = w_tmp[34:0];
            n_stage.root = {i_stage.root[31:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.rad  <= n_stage.rad;
            r_stage.rem  <= n_stage.rem;
            r_stage.root <= n_stage.root;
            r_stage.mag  <= n_stage.mag;
            r_stage.neg  <= n_stage.neg;
        end
    end

    assign o_stage = r_stage;
endmodule

// ----- hw/rtl/vne_div_cell.sv -----
module vne_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  vne_pkg::t_dv_stage i_stage,
    output vne_pkg::t_dv_stage o_stage
);
    import vne_pkg::*;

    t_dv_stage r_stage;
    t_dv_stage n_stage;
    logic [NumLanes-1:0][33:0] w_tmp;

    always_comb begin
        n_stage = i_stage;
        for (int i = 0; i < NumLanes; i++) begin
            w_tmp[i]          = {i_stage.rem[i], i_stage.dvd[i][16]};
            n_stage.dvd[i]    = {i_stage.dvd[i][15:0], 1'b0};
            if (w_tmp[i] >= {1'b0, i_stage.root}) begin
                n_stage.rem[i] = 33'(w_tmp[i] - {1'b0, i_stage.root});
                n_stage.quo[i] = {i_stage.quo[i][15:0], 1'b1};
            end else begin
                n_stage.rem[i] = w_tmp[i][32:0];
                n_stage.quo[i] = {i_stage.quo[i][15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.root <= n_stage.root;
            r_stage.rem  <= n_stage.rem;
            r_stage.dvd  <= n_stage.dvd;
            r_stage.quo  <= n_stage.quo;
            r_stage.neg  <= n_stage.neg;
        end
    end

    assign o_stage = r_stage;
endmodule
